// ===== design/jsdec_pkg.sv =====
// package: payload types, table entry layout, sequencer states and sizes for the schedule decoder
`timescale 1ns / 1ps

package jsdec_pkg;

  localparam int MACHINES_DEF = 16;
  localparam int JOBS_DEF     = 32;

  localparam int JOB_ID_W  = 5;
  localparam int MACH_ID_W = 4;
  localparam int DUR_W     = 16;
  localparam int TIME_W    = 32;

  // generation tag kept with every table entry; a first_item beat moves to the next one
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef struct packed {
    logic [JOB_ID_W-1:0]  job_id;
    logic [MACH_ID_W-1:0] machine_id;
    logic [DUR_W-1:0]     duration;
    logic                 first_item;
    logic                 last_item;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0] op_start;
    logic [TIME_W-1:0] op_end;
    logic [TIME_W-1:0] makespan;
    logic              schedule_done;
  } out_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [TIME_W-1:0]  free_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } seq_state_t;

endpackage

// ===== design/jsdec_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module jsdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/job_shop_schedule_decoder.sv =====
// top level: job-shop schedule decoder with machine and job free-time tables in ram
//
//   port group  dir  handshake           payload
//   in_*        in   in_valid/in_stall   jsdec_pkg::in_t  (job, machine, duration, flags)
//   out_*       out  out_valid/out_stall jsdec_pkg::out_t (start, end, makespan, done)
//
// one operation per cycle sustained while no stall or clearing pass holds the flow; a result
//   passes through the read stage and the output register before it is on out_*
// the ram read is issued as the beat is taken, max/add/write-back as it leaves the read stage;
//   the previous write is forwarded since the ram returns old data on a same-edge write
// after reset a clearing pass over max(MACHINES, JOBS) entries holds in_stall high
// first_item bumps an 8-bit generation tag instead of clearing; when such a beat wraps the tag
//   past its all-ones value, the same clearing pass runs before that beat is processed
// out_stall holds the output register; one more beat is taken into the read stage meanwhile
`timescale 1ns / 1ps

module job_shop_schedule_decoder #(
  parameter int MACHINES = jsdec_pkg::MACHINES_DEF,
  parameter int JOBS     = jsdec_pkg::JOBS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  jsdec_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output jsdec_pkg::out_t  out_data
);

  localparam int MACH_AW  = MACHINES > 1 ? $clog2(MACHINES) : 1;
  localparam int JOB_AW   = JOBS > 1 ? $clog2(JOBS) : 1;
  localparam int MACH_XW  = MACH_AW + jsdec_pkg::MACH_ID_W;
  localparam int JOB_XW   = JOB_AW + jsdec_pkg::JOB_ID_W;
  localparam int SWEEP_D  = MACHINES > JOBS ? MACHINES : JOBS;
  localparam int SWEEP_W  = SWEEP_D > 1 ? $clog2(SWEEP_D) : 1;
  localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(SWEEP_D - 1);
  localparam int TW = jsdec_pkg::TIME_W;
  localparam int EW = jsdec_pkg::EPOCH_W;

  // sequencer
  jsdec_pkg::seq_state_t state_r, state_nxt;
  logic [SWEEP_W-1:0]    sweep_cnt_r;
  logic                  sweeping;
  logic                  running;
  logic                  swept_r;

  // read stage
  logic                  s1_valid_r;
  jsdec_pkg::in_t        s1_item_r;
  logic [JOB_AW-1:0]     s1_job_addr_r;
  logic [MACH_AW-1:0]    s1_mach_addr_r;
  logic                  s1_job_ok_r;
  logic                  s1_mach_ok_r;

  // last write, for forwarding
  logic                  lw_job_we_r;
  logic                  lw_mach_we_r;
  logic [JOB_AW-1:0]     lw_job_addr_r;
  logic [MACH_AW-1:0]    lw_mach_addr_r;
  logic [TW-1:0]         lw_end_r;

  logic [EW-1:0]         epoch_r;
  logic [TW-1:0]         makespan_r;

  logic                  out_valid_r;
  jsdec_pkg::out_t       out_data_r;

  // ram ports
  logic                  job_we, mach_we;
  logic [JOB_AW-1:0]     job_waddr;
  logic [MACH_AW-1:0]    mach_waddr;
  jsdec_pkg::entry_t     job_wdata, mach_wdata, job_rdata, mach_rdata;

  // beat decode
  logic                  accept;
  logic [JOB_XW-1:0]     in_job_x;
  logic [MACH_XW-1:0]    in_mach_x;
  logic [JOB_AW-1:0]     in_job_addr;
  logic [MACH_AW-1:0]    in_mach_addr;

  // schedule math
  logic                  need_sweep;
  logic                  s1_go;
  logic [TW-1:0]         jfree, mfree, s1_start, s1_end, ms_base, ms_new;
  logic [TW:0]           s1_sum;
  logic [EW-1:0]         epoch_use;

  assign in_job_x     = JOB_XW'(in_data.job_id);
  assign in_mach_x    = MACH_XW'(in_data.machine_id);
  assign in_job_addr  = in_job_x[JOB_AW-1:0];
  assign in_mach_addr = in_mach_x[MACH_AW-1:0];

  assign accept = in_valid && !in_stall;

  // wrapping generation tag needs the tables cleared before this beat can use them
  assign need_sweep = s1_valid_r && s1_item_r.first_item && (epoch_r == jsdec_pkg::EPOCH_MAX)
                      && !swept_r;
  assign s1_go      = s1_valid_r && running && !need_sweep && (!out_valid_r || !out_stall);
  assign in_stall   = !running || (s1_valid_r && !s1_go);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jsdec_pkg::ST_SWEEP: begin
        if (sweep_cnt_r == SWEEP_LAST) begin
          state_nxt = jsdec_pkg::ST_RUN;
        end
      end
      jsdec_pkg::ST_RUN: begin
        if (need_sweep) begin
          state_nxt = jsdec_pkg::ST_SWEEP;
        end
      end
      default: state_nxt = jsdec_pkg::ST_SWEEP;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sweeping = 1'b0;
    running  = 1'b0;
    unique case (state_r)
      jsdec_pkg::ST_SWEEP: sweeping = 1'b1;
      jsdec_pkg::ST_RUN:   running  = 1'b1;
      default:             sweeping = 1'b0;
    endcase
  end

  // free times: stale generation or first beat reads zero, last write wins, out of range is zero
  always_comb begin
    jfree = '0;
    mfree = '0;
    if (!s1_item_r.first_item) begin
      if (job_rdata.tag == epoch_r) begin
        jfree = job_rdata.free_time;
      end
      if (mach_rdata.tag == epoch_r) begin
        mfree = mach_rdata.free_time;
      end
      if (lw_job_we_r && (lw_job_addr_r == s1_job_addr_r)) begin
        jfree = lw_end_r;
      end
      if (lw_mach_we_r && (lw_mach_addr_r == s1_mach_addr_r)) begin
        mfree = lw_end_r;
      end
    end
    if (!s1_job_ok_r) begin
      jfree = '0;
    end
    if (!s1_mach_ok_r) begin
      mfree = '0;
    end
  end

  assign s1_start  = (mfree > jfree) ? mfree : jfree;
  assign s1_sum    = {1'b0, s1_start} + (TW + 1)'(s1_item_r.duration);
  assign s1_end    = s1_sum[TW] ? '1 : s1_sum[TW-1:0];
  assign ms_base   = s1_item_r.first_item ? '0 : makespan_r;
  assign ms_new    = (s1_end > ms_base) ? s1_end : ms_base;
  assign epoch_use = s1_item_r.first_item ? epoch_r + EW'(1) : epoch_r;

  // write port: clearing pass or write-back of the operation in the read stage
  always_comb begin
    if (sweeping) begin
      job_we     = (32'(sweep_cnt_r) < 32'(JOBS));
      mach_we    = (32'(sweep_cnt_r) < 32'(MACHINES));
      job_waddr  = sweep_cnt_r[JOB_AW-1:0];
      mach_waddr = sweep_cnt_r[MACH_AW-1:0];
      job_wdata  = '0;
      mach_wdata = '0;
    end else begin
      job_we     = s1_go && s1_job_ok_r;
      mach_we    = s1_go && s1_mach_ok_r;
      job_waddr  = s1_job_addr_r;
      mach_waddr = s1_mach_addr_r;
      job_wdata  = '{tag: epoch_use, free_time: s1_end};
      mach_wdata = '{tag: epoch_use, free_time: s1_end};
    end
  end

  jsdec_ram #(
    .WIDTH (jsdec_pkg::ENTRY_W),
    .DEPTH (JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_waddr),
    .wdata (job_wdata),
    .re    (accept),
    .raddr (in_job_addr),
    .rdata (job_rdata)
  );

  jsdec_ram #(
    .WIDTH (jsdec_pkg::ENTRY_W),
    .DEPTH (MACHINES)
  ) u_mach_ram (
    .clk   (clk),
    .we    (mach_we),
    .waddr (mach_waddr),
    .wdata (mach_wdata),
    .re    (accept),
    .raddr (in_mach_addr),
    .rdata (mach_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= jsdec_pkg::ST_SWEEP;
      sweep_cnt_r  <= '0;
      swept_r      <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      lw_job_we_r  <= 1'b0;
      lw_mach_we_r <= 1'b0;
      epoch_r      <= '0;
      makespan_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (sweeping) begin
        sweep_cnt_r <= (sweep_cnt_r == SWEEP_LAST) ? '0 : sweep_cnt_r + SWEEP_W'(1);
      end
      if (sweeping && (sweep_cnt_r == SWEEP_LAST)) begin
        swept_r <= 1'b1;
      end else if (s1_go) begin
        swept_r <= 1'b0;
      end
      s1_valid_r  <= accept || (s1_valid_r && !s1_go);
      out_valid_r <= s1_go || (out_valid_r && out_stall);
      if (s1_go) begin
        lw_job_we_r  <= s1_job_ok_r;
        lw_mach_we_r <= s1_mach_ok_r;
        epoch_r      <= epoch_use;
        makespan_r   <= ms_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r      <= in_data;
      s1_job_addr_r  <= in_job_addr;
      s1_mach_addr_r <= in_mach_addr;
      s1_job_ok_r    <= (32'(in_data.job_id) < 32'(JOBS));
      s1_mach_ok_r   <= (32'(in_data.machine_id) < 32'(MACHINES));
    end
    if (s1_go) begin
      lw_job_addr_r            <= s1_job_addr_r;
      lw_mach_addr_r           <= s1_mach_addr_r;
      lw_end_r                 <= s1_end;
      out_data_r.op_start      <= s1_start;
      out_data_r.op_end        <= s1_end;
      out_data_r.makespan      <= ms_new;
      out_data_r.schedule_done <= s1_item_r.last_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // end never falls below start, saturation included
  a_end_ge_start: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> (s1_end >= s1_start))
    else $error("end time below start time");

  // makespan only grows within one chromosome
  a_makespan_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_item_r.first_item) |=> (makespan_r >= $past(makespan_r)))
    else $error("makespan decreased without a clear");

  // clearing pass and operation write-back never share the write port
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !s1_go)
    else $error("write-back during clearing pass");

  // clearing pass ends only after the last entry
  a_sweep_len: assert property (@(posedge clk) disable iff (!rst_n)
    (sweeping && (state_nxt == jsdec_pkg::ST_RUN)) |-> (sweep_cnt_r == SWEEP_LAST))
    else $error("clearing pass ended early");

  // a taken beat lands in the read stage
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted beat lost");

endmodule
